### rtl/core/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants shared by the 1-Wire master slot engine.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned CNT_W = 9;
  localparam int unsigned FUNC_W = 3;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_RESET   = 3'd1,
    FUNC_WRITE   = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_RELEASE = 3'd4
  } func_code_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LOW = 4'd1,
    PH_RST_WT  = 4'd2,
    PH_RST_REC = 4'd3,
    PH_WR_LOW  = 4'd4,
    PH_WR_REL  = 4'd5,
    PH_RD_LOW  = 4'd6,
    PH_RD_WT   = 4'd7,
    PH_RD_REC  = 4'd8
  } phase_t;

  localparam logic [CNT_W-1:0] RST_WAIT_US  = 9'd70;
  localparam logic [CNT_W-1:0] RST_REC_US   = 9'd410;
  localparam logic [CNT_W-1:0] WR1_LOW_US   = 9'd10;
  localparam logic [CNT_W-1:0] WR1_REL_US   = 9'd55;
  localparam logic [CNT_W-1:0] WR0_LOW_US   = 9'd65;
  localparam logic [CNT_W-1:0] WR0_REL_US   = 9'd5;
  localparam logic [CNT_W-1:0] RD_LOW_US    = 9'd3;
  localparam logic [CNT_W-1:0] RD_WAIT_US   = 9'd10;
  localparam logic [CNT_W-1:0] RD_REC_US    = 9'd53;

endpackage

### rtl/core/one_wire_master_slot_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_master_slot_engine_core
// 1-Wire bus master: reset pulse, byte write, byte read and strong pull-up.
//
// Input channel (in_*): one transfer is either a microsecond tick carrying
// the sampled bus level, or a command taken while the engine is idle
// (commands arriving while busy are dropped without using time).
// Output channel (out_*): exactly one transfer per input transfer, giving
// bus drive, pull-up, busy/done flags, presence level and last read byte
// for the coming microsecond.
// Path: input register, then result register. Throughput: one transfer per
// clock while out_stall is low; the per-item work is one counter decrement
// and a phase update between those two registers.
// Stall: when out_stall holds the result register, the input register holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous): engine idle, counters cleared, presence
// level reads 1, pull-up off, read byte 0, both pipeline stages empty.
// ----------------------------------------------------------------------------
module one_wire_master_slot_engine_core #(
  parameter int unsigned RESET_LOW_US = 480
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_power_after,
  input  logic       in_line_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_drive_low,
  output logic       out_pullup_on,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_presence_level,
  output logic [7:0] out_read_byte
);
  import owm_pkg::*;

  logic              s1_valid_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [7:0]        s1_data_r;
  logic              s1_power_r;
  logic              s1_level_r;
  logic              s1_move;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic [2:0]       bit_r, bit_nxt, bit_inc;
  logic [7:0]       shift_r, shift_nxt;
  logic             presence_r, presence_nxt;
  logic             pu_active_r, pu_active_nxt;
  logic             pu_pending_r, pu_pending_nxt;
  logic [7:0]       last_read_r, last_read_nxt;
  logic             done_nxt;

  logic       out_valid_r;
  logic       out_drive_low_r, out_pullup_on_r, out_busy_r, out_done_r, out_presence_r;
  logic [7:0] out_read_byte_r;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r  <= in_func;
      s1_data_r  <= in_data_byte;
      s1_power_r <= in_power_after;
      s1_level_r <= in_line_level;
    end
  end

  assign cnt_dec = cnt_r - CNT_W'(1);
  assign bit_inc = bit_r + 3'd1;

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    presence_nxt   = presence_r;
    pu_active_nxt  = pu_active_r;
    pu_pending_nxt = pu_pending_r;
    last_read_nxt  = last_read_r;
    done_nxt       = 1'b0;
    if (s1_func_r == FUNC_TICK) begin
      if (phase_r != PH_IDLE) begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          case (phase_r)
            PH_RST_LOW: begin
              phase_nxt = PH_RST_WT;
              cnt_nxt   = RST_WAIT_US;
            end
            PH_RST_WT: begin
              presence_nxt = s1_level_r;
              phase_nxt    = PH_RST_REC;
              cnt_nxt      = RST_REC_US;
            end
            PH_RST_REC: begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
            PH_WR_LOW: begin
              phase_nxt = PH_WR_REL;
              cnt_nxt   = shift_r[bit_r] ? WR1_REL_US : WR0_REL_US;
            end
            PH_WR_REL: begin
              if (bit_r == 3'd7) begin
                bit_nxt        = '0;
                phase_nxt      = PH_IDLE;
                pu_active_nxt  = pu_active_r | pu_pending_r;
                pu_pending_nxt = 1'b0;
                done_nxt       = 1'b1;
              end else begin
                bit_nxt   = bit_inc;
                phase_nxt = PH_WR_LOW;
                cnt_nxt   = shift_r[bit_inc] ? WR1_LOW_US : WR0_LOW_US;
              end
            end
            PH_RD_LOW: begin
              phase_nxt = PH_RD_WT;
              cnt_nxt   = RD_WAIT_US;
            end
            PH_RD_WT: begin
              shift_nxt = {s1_level_r, shift_r[7:1]};
              phase_nxt = PH_RD_REC;
              cnt_nxt   = RD_REC_US;
            end
            PH_RD_REC: begin
              if (bit_r == 3'd7) begin
                bit_nxt       = '0;
                last_read_nxt = shift_r;
                phase_nxt     = PH_IDLE;
                done_nxt      = 1'b1;
              end else begin
                bit_nxt   = bit_inc;
                phase_nxt = PH_RD_LOW;
                cnt_nxt   = RD_LOW_US;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end else if (phase_r == PH_IDLE) begin
      case (s1_func_r)
        FUNC_RESET: begin
          pu_active_nxt  = 1'b0;
          pu_pending_nxt = 1'b0;
          phase_nxt      = PH_RST_LOW;
          cnt_nxt        = CNT_W'(RESET_LOW_US);
        end
        FUNC_WRITE: begin
          pu_active_nxt  = 1'b0;
          pu_pending_nxt = s1_power_r;
          shift_nxt      = s1_data_r;
          bit_nxt        = '0;
          phase_nxt      = PH_WR_LOW;
          cnt_nxt        = s1_data_r[0] ? WR1_LOW_US : WR0_LOW_US;
        end
        FUNC_READ: begin
          pu_active_nxt  = 1'b0;
          pu_pending_nxt = 1'b0;
          shift_nxt      = '0;
          bit_nxt        = '0;
          phase_nxt      = PH_RD_LOW;
          cnt_nxt        = RD_LOW_US;
        end
        FUNC_RELEASE: begin
          pu_active_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cnt_r        <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      presence_r   <= 1'b1;
      pu_active_r  <= 1'b0;
      pu_pending_r <= 1'b0;
      last_read_r  <= '0;
    end else if (s1_move) begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      presence_r   <= presence_nxt;
      pu_active_r  <= pu_active_nxt;
      pu_pending_r <= pu_pending_nxt;
      last_read_r  <= last_read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_drive_low_r <= (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                         (phase_nxt == PH_RD_LOW);
      out_pullup_on_r <= pu_active_nxt;
      out_busy_r      <= (phase_nxt != PH_IDLE);
      out_done_r      <= done_nxt;
      out_presence_r  <= presence_nxt;
      out_read_byte_r <= last_read_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_low      = out_drive_low_r;
  assign out_pullup_on      = out_pullup_on_r;
  assign out_busy_res       = out_busy_r;
  assign out_done_res       = out_done_r;
  assign out_presence_level = out_presence_r;
  assign out_read_byte      = out_read_byte_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("done flagged while still busy");

  a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drive_low_r |-> out_busy_r)
    else $error("line driven low while idle");

  a_no_pullup_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_busy_r |-> !out_pullup_on_r)
    else $error("strong pull-up on during a bus sequence");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> cnt_r != '0)
    else $error("active phase with expired counter");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("result register empty after stage move");

endmodule

### tb/owm_slot_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_slot_monitor
// Watches both channels of the 1-Wire master slot engine. Every input
// transfer is run through a cycle-free model of the slot timing (phase,
// microsecond countdown, bit index, shift byte, presence and pull-up state)
// and the bus view it gives is queued. Every result transfer is compared,
// field by field, with the oldest queued view.
// ----------------------------------------------------------------------------
module owm_slot_monitor #(
  parameter int unsigned RESET_LOW_US = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_power_after,
  input  logic        in_line_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_drive_low,
  input  logic        out_pullup_on,
  input  logic        out_busy_res,
  input  logic        out_done_res,
  input  logic        out_presence_level,
  input  logic [7:0]  out_read_byte,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned checked
);
  import owm_pkg::*;

  typedef struct packed {
    logic       drive_low;
    logic       pullup_on;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] rd_byte;
  } bus_view_t;

  phase_t           ph;
  logic [CNT_W-1:0] us_left;
  logic [2:0]       bit_idx;
  logic [7:0]       shreg;
  logic             presence;
  logic             pu_active;
  logic             pu_pending;
  logic [7:0]       last_rd;
  bus_view_t        bus_view_q[$];
  int unsigned      n_err = 0;
  int unsigned      n_pend = 0;
  int unsigned      n_chk = 0;

  assign errors  = n_err;
  assign pending = n_pend;
  assign checked = n_chk;

  function automatic logic [CNT_W-1:0] low_us(input logic b);
    return b ? WR1_LOW_US : WR0_LOW_US;
  endfunction

  task automatic advance_us(input logic lvl, output logic fin);
    fin = 1'b0;
    if (ph != PH_IDLE) begin
      us_left = us_left - CNT_W'(1);
      if (us_left == '0) begin
        case (ph)
          PH_RST_LOW: begin
            ph      = PH_RST_WT;
            us_left = RST_WAIT_US;
          end
          PH_RST_WT: begin
            presence = lvl;
            ph       = PH_RST_REC;
            us_left  = RST_REC_US;
          end
          PH_RST_REC: begin
            ph  = PH_IDLE;
            fin = 1'b1;
          end
          PH_WR_LOW: begin
            ph      = PH_WR_REL;
            us_left = shreg[bit_idx] ? WR1_REL_US : WR0_REL_US;
          end
          PH_WR_REL: begin
            if (bit_idx == 3'd7) begin
              bit_idx    = '0;
              ph         = PH_IDLE;
              pu_active  = pu_active | pu_pending;
              pu_pending = 1'b0;
              fin        = 1'b1;
            end else begin
              bit_idx = bit_idx + 3'd1;
              ph      = PH_WR_LOW;
              us_left = low_us(shreg[bit_idx]);
            end
          end
          PH_RD_LOW: begin
            ph      = PH_RD_WT;
            us_left = RD_WAIT_US;
          end
          PH_RD_WT: begin
            shreg   = {lvl, shreg[7:1]};
            ph      = PH_RD_REC;
            us_left = RD_REC_US;
          end
          PH_RD_REC: begin
            if (bit_idx == 3'd7) begin
              bit_idx = '0;
              last_rd = shreg;
              ph      = PH_IDLE;
              fin     = 1'b1;
            end else begin
              bit_idx = bit_idx + 3'd1;
              ph      = PH_RD_LOW;
              us_left = RD_LOW_US;
            end
          end
          default: begin
            ph = PH_IDLE;
          end
        endcase
      end
    end
  endtask

  task automatic apply_item(input logic [2:0] fn, input logic [7:0] dat, input logic pwr,
                            input logic lvl, output bus_view_t view);
    logic fin;
    fin = 1'b0;
    if (fn == FUNC_TICK) begin
      advance_us(lvl, fin);
    end else if (ph == PH_IDLE) begin
      case (fn)
        FUNC_RESET: begin
          pu_active  = 1'b0;
          pu_pending = 1'b0;
          ph         = PH_RST_LOW;
          us_left    = RESET_LOW_US[CNT_W-1:0];
        end
        FUNC_WRITE: begin
          pu_active  = 1'b0;
          pu_pending = pwr;
          shreg      = dat;
          bit_idx    = '0;
          ph         = PH_WR_LOW;
          us_left    = low_us(dat[0]);
        end
        FUNC_READ: begin
          pu_active  = 1'b0;
          pu_pending = 1'b0;
          shreg      = '0;
          bit_idx    = '0;
          ph         = PH_RD_LOW;
          us_left    = RD_LOW_US;
        end
        FUNC_RELEASE: begin
          pu_active = 1'b0;
        end
        default: begin
        end
      endcase
    end
    view.drive_low = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);
    view.pullup_on = pu_active;
    view.busy      = (ph != PH_IDLE);
    view.done      = fin;
    view.presence  = presence;
    view.rd_byte   = last_rd;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    bus_view_t view;
    if (!rst_n) begin
      ph         = PH_IDLE;
      us_left    = '0;
      bit_idx    = '0;
      shreg      = '0;
      presence   = 1'b1;
      pu_active  = 1'b0;
      pu_pending = 1'b0;
      last_rd    = '0;
      bus_view_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (bus_view_q.size() == 0) begin
          $error("result transfer with no input outstanding");
          n_err++;
        end else begin
          view = bus_view_q.pop_front();
          n_chk++;
          check_field("drive_low", 8'(view.drive_low), 8'(out_drive_low));
          check_field("pullup_on", 8'(view.pullup_on), 8'(out_pullup_on));
          check_field("busy_res", 8'(view.busy), 8'(out_busy_res));
          check_field("done_res", 8'(view.done), 8'(out_done_res));
          check_field("presence_level", 8'(view.presence), 8'(out_presence_level));
          check_field("read_byte", view.rd_byte, out_read_byte);
        end
      end
      if (in_valid && !in_stall) begin
        apply_item(in_func, in_data_byte, in_power_after, in_line_level, view);
        bus_view_q.push_back(view);
      end
    end
    n_pend = bus_view_q.size();
  end

endmodule

### tb/one_wire_master_slot_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_master_slot_engine_core_tb
// Drives idle ticks, spare codes, a pull-up release, a full byte write with
// strong pull-up and a byte read cut short by the item budget into the
// 1-Wire master, with random line levels, stray commands while busy and
// random gaps and stalls on both channels. A monitor checks every result.
// ----------------------------------------------------------------------------
module one_wire_master_slot_engine_core_tb;
  import owm_pkg::*;

  localparam int unsigned RESET_LOW_US = 480;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned ITEM_TARGET  = 750;
  localparam int unsigned SETTLE_CYC   = 8;

  localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  typedef enum int unsigned {LV_LOW, LV_HIGH, LV_RAND} level_mode_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func        = FUNC_TICK;
  logic [7:0]  in_data_byte   = '0;
  logic        in_power_after = 1'b0;
  logic        in_line_level  = 1'b1;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_drive_low;
  logic        out_pullup_on;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_presence_level;
  logic [7:0]  out_read_byte;

  logic        in_acc_q = 1'b0;
  logic        calm     = 1'b0;
  logic        draining = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_wr  = 0;
  int unsigned n_rd  = 0;
  int unsigned n_misc = 0;
  int unsigned chk_errors;
  int unsigned chk_pending;
  int unsigned chk_checked;

  one_wire_master_slot_engine_core #(
    .RESET_LOW_US(RESET_LOW_US)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .in_power_after    (in_power_after),
    .in_line_level     (in_line_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_low     (out_drive_low),
    .out_pullup_on     (out_pullup_on),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_presence_level(out_presence_level),
    .out_read_byte     (out_read_byte)
  );

  owm_slot_monitor #(
    .RESET_LOW_US(RESET_LOW_US)
  ) i_mon (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .in_power_after    (in_power_after),
    .in_line_level     (in_line_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_low     (out_drive_low),
    .out_pullup_on     (out_pullup_on),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_presence_level(out_presence_level),
    .out_read_byte     (out_read_byte),
    .errors            (chk_errors),
    .pending           (chk_pending),
    .checked           (chk_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_acc_q <= rst_n && in_valid && !in_stall;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic pick_level(input level_mode_t mode);
    case (mode)
      LV_LOW:  return 1'b0;
      LV_HIGH: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic int unsigned cmd_us(input logic [2:0] fn, input logic [7:0] dat);
    int unsigned us;
    int          i;
    us = 0;
    case (fn)
      FUNC_RESET: begin
        us = RESET_LOW_US + RST_WAIT_US + RST_REC_US;
      end
      FUNC_WRITE: begin
        for (i = 0; i < 8; i++)
          us += dat[i] ? WR1_LOW_US + WR1_REL_US : WR0_LOW_US + WR0_REL_US;
      end
      FUNC_READ: begin
        us = 8 * (RD_LOW_US + RD_WAIT_US + RD_REC_US);
      end
      default: begin
        us = 0;
      end
    endcase
    return us;
  endfunction

  always @(negedge clk) begin
    if (draining) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (rst_n && !calm && $urandom_range(0, 5) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("one_wire_master_slot_engine_core_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // enter and leave on a falling edge
  task automatic send_item(input logic [2:0] fn, input logic [7:0] dat, input logic pwr,
                           input logic lvl);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func        <= fn;
    in_data_byte   <= dat;
    in_power_after <= pwr;
    in_line_level  <= lvl;
    in_valid       <= 1'b1;
    do @(negedge clk); while (!in_acc_q);
    n_items++;
  endtask

  task automatic run_cmd(input logic [2:0] fn, input logic [7:0] dat, input logic pwr,
                         input level_mode_t mode, input bit noise);
    int unsigned us;
    int unsigned tail;
    int unsigned i;
    us   = cmd_us(fn, dat);
    tail = $urandom_range(0, 2);
    case (fn)
      FUNC_WRITE: n_wr++;
      FUNC_READ:  n_rd++;
      default:    n_misc++;
    endcase
    send_item(fn, dat, pwr, pick_level(mode));
    for (i = 0; i < us + tail && n_items < ITEM_TARGET; i++) begin
      if (noise && i < us && $urandom_range(0, 15) == 0)
        send_item(3'($urandom_range(FUNC_RESET, FUNC_SPARE_7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                pick_level(mode));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    calm = 1'b1;
    run_cmd(FUNC_TICK, 8'h00, 1'b0, LV_LOW, 1'b0);
    run_cmd(FUNC_SPARE_5, 8'hFF, 1'b1, LV_RAND, 1'b0);
    run_cmd(FUNC_SPARE_6, 8'h00, 1'b0, LV_RAND, 1'b0);
    run_cmd(FUNC_SPARE_7, 8'hFF, 1'b1, LV_RAND, 1'b0);
    calm = 1'b0;
    run_cmd(FUNC_RELEASE, 8'h00, 1'b0, LV_RAND, 1'b0);
    run_cmd(FUNC_TICK, 8'hFF, 1'b1, LV_HIGH, 1'b0);
    run_cmd(FUNC_WRITE, 8'hFF, 1'b1, LV_RAND, 1'b1);
    run_cmd(FUNC_TICK, 8'h00, 1'b0, LV_RAND, 1'b0);
    run_cmd(FUNC_READ, 8'h00, 1'b0, LV_RAND, 1'b1);

    in_valid <= 1'b0;
    draining <= 1'b1;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    $display("Sent %0d byte writes, %0d byte reads and %0d other codes, with stray",
             n_wr, n_rd, n_misc);
    $display("commands while busy, in %0d input transfers; %0d results compared, %0d mismatches",
             n_items, chk_checked, chk_errors);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("one_wire_master_slot_engine_core_tb OK");
    end else begin
      $display("one_wire_master_slot_engine_core_tb NOT OK");
    end
    $finish;
  end

endmodule
